### hdl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared field widths, command and status codes, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

   // Field widths of the command, result and register ports.
   localparam int CMD_W    = 3;
   localparam int IDX_W    = 10;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 11;

   // Slot count after reset.
   localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_SET        = 3'd0,
      CMD_CLEAR      = 3'd1,
      CMD_TEST       = 3'd2,
      CMD_FIND_FREE  = 3'd3,
      CMD_FIND_SET   = 3'd4,
      CMD_ALLOC_FREE = 3'd5,
      CMD_TAKE_SET   = 3'd6
   } cmd_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 2'd0,
      STAT_NONE_FOUND   = 2'd1,
      STAT_OUT_OF_RANGE = 2'd2
   } status_type;

   // Which result the datapath registers on the response beat.
   typedef enum logic [2:0] {
      EMIT_NONE  = 3'd0,
      EMIT_BIT   = 3'd1,
      EMIT_FOUND = 3'd2,
      EMIT_MISS  = 3'd3,
      EMIT_ECHO  = 3'd4
   } emit_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     latch;
      logic     scan_init;
      logic     scan_step;
      logic     hit_capture;
      logic     div;
      logic     rd_idx;
      emit_type emit;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic oor;
      logic hit;
      logic last;
   } sts_type;

endpackage

`default_nettype wire

### hdl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Sequences one command at a time: index split and read-modify-write for the
// named-bit commands, a one-word-per-cycle scan for searches, else an echo.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bsa_pkg::CMD_W-1:0]   req_cmd,
   input  wire bsa_pkg::sts_type            sts,
   output bsa_pkg::ctl_type                 ctl,
   output logic                             busy
);

   import bsa_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIV    = 7'b0000010,
      ST_RDIDX  = 7'b0000100,
      ST_MODIFY = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_FOUND  = 7'b0100000,
      ST_ECHO   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.emit = EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               if (req_cmd inside {CMD_SET, CMD_CLEAR, CMD_TEST}) begin
                  state_in = ST_DIV;
               end else if (req_cmd inside {CMD_FIND_FREE, CMD_FIND_SET,
                                            CMD_ALLOC_FREE, CMD_TAKE_SET}) begin
                  ctl.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_ECHO;
               end
            end
         end
         ST_DIV: begin
            // An index at or above the count answers at once and touches nothing.
            if (sts.oor) begin
               ctl.emit = EMIT_ECHO;
               state_in = ST_IDLE;
            end else begin
               ctl.div  = 1'b1;
               state_in = ST_RDIDX;
            end
         end
         ST_RDIDX: begin
            ctl.rd_idx = 1'b1;
            state_in   = ST_MODIFY;
         end
         ST_MODIFY: begin
            ctl.emit = EMIT_BIT;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.hit) begin
               ctl.hit_capture = 1'b1;
               state_in        = ST_FOUND;
            end else if (sts.last) begin
               ctl.emit = EMIT_MISS;
               state_in = ST_IDLE;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         ST_FOUND: begin
            ctl.emit = EMIT_FOUND;
            state_in = ST_IDLE;
         end
         ST_ECHO: begin
            ctl.emit = EMIT_ECHO;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // A result beat always returns the controller to idle.
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit != EMIT_NONE) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after a result");

   // The scan only advances on a word that neither hit nor ended the scan.
   a_step_clean: assert property (@(posedge clock) disable iff (reset)
      ctl.scan_step |-> (!sts.hit && !sts.last))
      else $error("scan advanced past a hit or the last word");

   // Exactly one state bit is set at all times.
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule

`default_nettype wire

### hdl/bsa_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator datapath
// Flag memory with per-word valid bits, slot count register, index split,
// word scan with lowest-bit select, and the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_datapath #(
   parameter int MAX_SLOTS = 1024,
   parameter int WORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bsa_pkg::ctl_type              ctl,
   output bsa_pkg::sts_type                   sts,
   input  wire logic [bsa_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [bsa_pkg::IDX_W-1:0]     req_slot_index,
   input  wire logic                          csr_wr_en,
   input  wire logic [bsa_pkg::CNT_W-1:0]     csr_wr_data,
   output logic                               rsp_strobe,
   output logic [bsa_pkg::IDX_W-1:0]          rsp_found_index,
   output logic [bsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_bit_value
);

   import bsa_pkg::*;

   localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BW  = $clog2(WORD_BITS);
   localparam int CW1 = $clog2(MAX_SLOTS + 2 * WORD_BITS + 1);
   localparam int XW  = (CW1 > CNT_W) ? CW1 : CNT_W;
   // Reciprocal for the index split: exact floor(idx / WORD_BITS) for any
   // IDX_W-bit index when the shift is IDX_W + BW.
   localparam int K   = IDX_W + BW;
   localparam int PW  = IDX_W + BW + 2;
   localparam int MW  = PW + IDX_W;
   localparam int QW  = AW + BW + 1;
   localparam logic [PW-1:0] RECIP = PW'(((1 << K) + WORD_BITS - 1) / WORD_BITS);

   // Latched command.
   logic [CMD_W-1:0]     cmd_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 oor_ff;
   logic [CNT_W-1:0]     slot_count_ff;

   // Index split.
   logic [AW-1:0]        q_ff;
   logic [AW-1:0]        q_in;
   logic [BW-1:0]        bit_ff;
   logic [BW-1:0]        bit_in;
   logic [MW-1:0]        prod;
   logic [MW-1:0]        q_shift;
   logic [QW-1:0]        qwb;

   // Scan.
   logic [AW-1:0]        cur_word_ff;
   logic [XW-1:0]        base_ff;
   logic [BW-1:0]        bitpos_ff;
   logic [WORD_BITS-1:0] wr_word_ff;

   // Flag memory.
   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // Response registers.
   logic                 rsp_strobe_ff;
   logic [IDX_W-1:0]     rsp_found_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_bit_ff;

   logic [XW-1:0]        active_cnt;
   logic                 oor_in;
   logic [WORD_BITS-1:0] word;
   logic [XW-1:0]        rem_cnt;
   logic [WORD_BITS-1:0] lim_mask;
   logic                 want;
   logic [WORD_BITS-1:0] cand;
   logic [WORD_BITS-1:0] lowbit;
   logic [BW-1:0]        enc;
   logic [WORD_BITS-1:0] onehot;
   logic [XW-1:0]        found_sum;
   logic                 is_idx_cmd;

   // Active slot count, clamped to the built capacity.
   assign active_cnt = (XW'(slot_count_ff) > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS)
                                                             : XW'(slot_count_ff);

   // Range check for the named-bit commands is done on the accepted beat.
   assign is_idx_cmd = (req_cmd == CMD_SET) || (req_cmd == CMD_CLEAR) ||
                       (req_cmd == CMD_TEST);
   assign oor_in     = is_idx_cmd && (XW'(req_slot_index) >= active_cnt);

   // Index split: quotient by reciprocal, remainder from the low bits.
   assign prod    = MW'(idx_ff) * MW'(RECIP);
   assign q_shift = prod >> K;
   assign q_in    = q_shift[AW-1:0];
   assign qwb     = QW'(q_ff) * QW'(WORD_BITS);
   assign bit_in  = idx_ff[BW-1:0] - qwb[BW-1:0];

   // Word as read, with never-written words reading as zero.
   assign word = rd_valid_ff ? rd_data_ff : '0;

   // Mask of the bits of the current word that lie below the count.
   assign rem_cnt = active_cnt - base_ff;
   always_comb begin
      if (active_cnt <= base_ff) begin
         lim_mask = '0;
      end else if (rem_cnt >= XW'(WORD_BITS)) begin
         lim_mask = {WORD_BITS{1'b1}};
      end else begin
         lim_mask = (WORD_BITS'(1) << rem_cnt[BW-1:0]) - WORD_BITS'(1);
      end
   end

   // Lowest candidate bit of the current word.
   assign want   = (cmd_ff == CMD_FIND_SET) || (cmd_ff == CMD_TAKE_SET);
   assign cand   = (want ? word : ~word) & lim_mask;
   assign lowbit = cand & (~cand + WORD_BITS'(1));

   always_comb begin
      enc = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (lowbit[b]) begin
            enc = enc | BW'(b);
         end
      end
   end

   assign sts.oor  = oor_ff;
   assign sts.hit  = |cand;
   assign sts.last = ((base_ff + XW'(WORD_BITS)) >= active_cnt) ||
                     (cur_word_ff == AW'(WORD_COUNT - 1));

   // Read address: word zero on scan start, next word on a step, split index.
   always_comb begin
      if (ctl.rd_idx) begin
         rd_addr = q_ff;
      end else if (ctl.scan_step) begin
         rd_addr = cur_word_ff + AW'(1);
      end else begin
         rd_addr = '0;
      end
   end

   // Write-back for set, clear, allocate and take.
   assign onehot    = WORD_BITS'(1) << bit_ff;
   assign found_sum = base_ff + XW'(bitpos_ff);
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = q_ff;
      wr_data = (cmd_ff == CMD_SET) ? (word | onehot) : (word & ~onehot);
      if (ctl.emit == EMIT_BIT) begin
         wr_en = (cmd_ff == CMD_SET) || (cmd_ff == CMD_CLEAR);
      end else if (ctl.emit == EMIT_FOUND) begin
         wr_en   = (cmd_ff == CMD_ALLOC_FREE) || (cmd_ff == CMD_TAKE_SET);
         wr_addr = cur_word_ff;
         wr_data = wr_word_ff;
      end
   end

   // Flag memory array with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Per-word valid bits, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Slot count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= CNT_RESET;
      end else if (csr_wr_en) begin
         slot_count_ff <= csr_wr_data;
      end
   end

   // Command latch and range flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         oor_ff <= 1'b0;
      end else if (ctl.latch) begin
         oor_ff <= oor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_slot_index;
      end
      if (ctl.div) begin
         q_ff <= q_in;
      end
      if (ctl.rd_idx) begin
         bit_ff <= bit_in;
      end
   end

   // Scan position and captured hit.
   always_ff @(posedge clock) begin
      if (ctl.scan_init) begin
         cur_word_ff <= '0;
         base_ff     <= '0;
      end else if (ctl.scan_step) begin
         cur_word_ff <= cur_word_ff + AW'(1);
         base_ff     <= base_ff + XW'(WORD_BITS);
      end
      if (ctl.hit_capture) begin
         bitpos_ff  <= enc;
         wr_word_ff <= word ^ lowbit;
      end
   end

   // Response beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (ctl.emit != EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.emit)
         EMIT_BIT: begin
            rsp_found_ff  <= idx_ff;
            rsp_status_ff <= STAT_OK;
            rsp_bit_ff    <= word[bit_ff];
         end
         EMIT_FOUND: begin
            rsp_found_ff  <= found_sum[IDX_W-1:0];
            rsp_status_ff <= STAT_OK;
            rsp_bit_ff    <= 1'b0;
         end
         EMIT_MISS: begin
            rsp_found_ff  <= '0;
            rsp_status_ff <= STAT_NONE_FOUND;
            rsp_bit_ff    <= 1'b0;
         end
         EMIT_ECHO: begin
            rsp_found_ff  <= idx_ff;
            rsp_status_ff <= oor_ff ? STAT_OUT_OF_RANGE : STAT_OK;
            rsp_bit_ff    <= 1'b0;
         end
         default: begin
            rsp_found_ff  <= rsp_found_ff;
            rsp_status_ff <= rsp_status_ff;
            rsp_bit_ff    <= rsp_bit_ff;
         end
      endcase
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_bit_value   = rsp_bit_ff;

   // An out-of-range command never writes the bitmap.
   a_no_oor_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !oor_ff)
      else $error("bitmap written by an out-of-range command");

   // Writes stay inside the flag memory.
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < WORD_COUNT))
      else $error("flag memory write beyond its depth");

   // Result beats are never back to back: every result state returns to idle, which emits nothing.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("two result beats in consecutive cycles");

   // A captured hit always lies below the slot count.
   a_hit_below_count: assert property (@(posedge clock) disable iff (reset)
      ctl.hit_capture |=> (found_sum < active_cnt))
      else $error("search hit at or above the slot count");

endmodule

`default_nettype wire

### hdl/bitmap_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator unit
// Slot flag bitmap with set, clear, test, find-first, allocate and take commands.
//
//   Channel   Ports                                            Direction
//   command   start, busy, req_cmd, req_slot_index             in (busy out)
//   result    rsp_strobe, rsp_found_index, rsp_status,         out
//             rsp_bit_value
//   register  csr_wr_en, csr_wr_data (slot count)              in
//
// A command beat is taken when start is high and busy is low; one result
// beat follows on rsp_strobe for a single cycle and cannot be stalled.
// Set, clear and test split the index and read the word, which set and clear
// then write back; an out-of-range index or an unknown command is echoed.
// Searches read one flag word per cycle through the memory's single read
// port and stop at the first hit or after the last word below the slot count,
// scanning at least one.
// Reset is synchronous; the bitmap reads as all clear through per-word
// valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_unit #(
   parameter int MAX_SLOTS = 1024,
   parameter int WORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [bsa_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [bsa_pkg::IDX_W-1:0]     req_slot_index,
   output logic                               rsp_strobe,
   output logic [bsa_pkg::IDX_W-1:0]          rsp_found_index,
   output logic [bsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_bit_value,
   input  wire logic                          csr_wr_en,
   input  wire logic [bsa_pkg::CNT_W-1:0]     csr_wr_data
);

   import bsa_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // Command sequencer.
   bsa_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .sts     (sts),
      .ctl     (ctl),
      .busy    (busy)
   );

   // Flag memory, search and response logic.
   bsa_datapath #(
      .MAX_SLOTS (MAX_SLOTS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_slot_index  (req_slot_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_found_index (rsp_found_index),
      .rsp_status      (rsp_status),
      .rsp_bit_value   (rsp_bit_value)
   );

endmodule

`default_nettype wire

### tb/bsa_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator reply checker
// Watches the command, result and register channels of the allocator. It
// keeps its own copy of the slot bitmap and the slot count, and works out the
// reply to each command beat. Each result beat is compared field by field
// with the oldest reply still owed.
// ----------------------------------------------------------------------------

module bsa_reply_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic [bsa_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [bsa_pkg::IDX_W-1:0]    req_slot_index,
   input  wire logic                         rsp_strobe,
   input  wire logic [bsa_pkg::IDX_W-1:0]    rsp_found_index,
   input  wire logic [bsa_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic                         rsp_bit_value,
   input  wire logic                         csr_wr_en,
   input  wire logic [bsa_pkg::CNT_W-1:0]    csr_wr_data,
   output int                                fail_count,
   output int                                replies_owed
);

   import bsa_pkg::*;

   localparam int SLOT_CAPACITY = 1024;

   typedef struct packed {
      logic [IDX_W-1:0] found_index;
      status_type       status;
      logic             bit_value;
   } slot_reply_type;

   // Shadow bitmap, slot count and the replies that are still owed.
   logic [SLOT_CAPACITY-1:0] slot_flags;
   logic [CNT_W-1:0]         slot_count;
   slot_reply_type           replies_due[$];

   // Apply one command to the shadow bitmap and return the reply it earns.
   function automatic slot_reply_type apply_slot_cmd(input logic [CMD_W-1:0] code,
                                                     input logic [IDX_W-1:0] idx);
      slot_reply_type reply;
      int             limit;
      int             pos;
      int             i;
      logic           want;
      logic           hit;
      reply.found_index = idx;
      reply.status      = STAT_OK;
      reply.bit_value   = 1'b0;
      limit = (slot_count > SLOT_CAPACITY) ? SLOT_CAPACITY : int'(slot_count);
      case (code)
         CMD_SET, CMD_CLEAR, CMD_TEST: begin
            if (idx >= limit) begin
               reply.status = STAT_OUT_OF_RANGE;
            end else begin
               reply.bit_value = slot_flags[idx];
               if (code == CMD_SET) slot_flags[idx] = 1'b1;
               else if (code == CMD_CLEAR) slot_flags[idx] = 1'b0;
            end
         end
         CMD_FIND_FREE, CMD_FIND_SET, CMD_ALLOC_FREE, CMD_TAKE_SET: begin
            want = (code == CMD_FIND_FREE || code == CMD_ALLOC_FREE) ? 1'b0 : 1'b1;
            hit  = 1'b0;
            pos  = 0;
            for (i = 0; i < limit && !hit; i++) begin
               if (slot_flags[i] == want) begin
                  hit = 1'b1;
                  pos = i;
               end
            end
            if (hit) begin
               reply.found_index = IDX_W'(pos);
               if (code == CMD_ALLOC_FREE) slot_flags[pos] = 1'b1;
               else if (code == CMD_TAKE_SET) slot_flags[pos] = 1'b0;
            end else begin
               reply.found_index = '0;
               reply.status      = STAT_NONE_FOUND;
            end
         end
         default: begin
            // Unknown code: the index is echoed and nothing changes.
         end
      endcase
      return reply;
   endfunction

   // Compare the current result beat with one owed reply.
   task automatic check_reply(input slot_reply_type want);
      if (rsp_found_index !== want.found_index) begin
         fail_count++;
         $display("%0t: found_index mismatch, expected %0d actual %0d",
                  $time, want.found_index, rsp_found_index);
      end
      if (rsp_status !== want.status) begin
         fail_count++;
         $display("%0t: status mismatch, expected %0d actual %0d",
                  $time, want.status, rsp_status);
      end
      if (rsp_bit_value !== want.bit_value) begin
         fail_count++;
         $display("%0t: bit_value mismatch, expected %0d actual %0d",
                  $time, want.bit_value, rsp_bit_value);
      end
   endtask

   // Sample mid-cycle, where every channel holds what the next rising edge
   // takes. A result beat is retired before a command beat on the same edge.
   always @(negedge clock) begin
      if (reset) begin
         slot_flags = '0;
         slot_count = CNT_RESET;
         replies_due.delete();
         fail_count   = 0;
         replies_owed = 0;
      end else begin
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with no reply owed, expected none actual %0d/%0d/%0d",
                        $time, rsp_found_index, rsp_status, rsp_bit_value);
            end else begin
               check_reply(replies_due.pop_front());
            end
         end
         if (start && !busy)
            replies_due.push_back(apply_slot_cmd(req_cmd, req_slot_index));
         if (csr_wr_en)
            slot_count = csr_wr_data;
         replies_owed = replies_due.size();
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Drives a directed run over the field extremes and special cases, then
// random bursts biased toward filling, emptying or neither, under several
// slot-count settings and sender idle rates. A checker beside the block
// predicts every reply; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;
   import bsa_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 163;
   localparam int MAX_GAP         = 20;
   localparam int STALL_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 40;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic [CMD_W-1:0]    req_cmd        = '0;
   logic [IDX_W-1:0]    req_slot_index = '0;
   logic                csr_wr_en      = 1'b0;
   logic [CNT_W-1:0]    csr_wr_data    = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [IDX_W-1:0]    rsp_found_index;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_bit_value;

   int               fail_count;
   int               replies_owed;
   int               idle_pct       = 0;
   int               commands_sent  = 0;
   int               settings_used  = 0;
   int               stall_cycles   = 0;
   logic [CNT_W-1:0] cur_count      = CNT_RESET;

   bitmap_slot_allocator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_slot_index (req_slot_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_found_index(rsp_found_index),
      .rsp_status     (rsp_status),
      .rsp_bit_value  (rsp_bit_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   bsa_reply_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_slot_index (req_slot_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_found_index(rsp_found_index),
      .rsp_status     (rsp_status),
      .rsp_bit_value  (rsp_bit_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .replies_owed   (replies_owed)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run after too many cycles with no beat on any channel.
   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Send one command beat after a random idle gap; returns on the edge that
   // takes the beat.
   task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [IDX_W-1:0] idx);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= code;
      req_slot_index <= idx;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      commands_sent++;
   endtask

   // Hold the sender off until every owed reply is back and the block is idle.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (replies_owed != 0);
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Change the slot count while the block is idle.
   task automatic write_slot_count(input logic [CNT_W-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_count = value;
      settings_used++;
   endtask

   initial begin
      int               ph;
      int               sent;
      int               bias;
      int               burst;
      int               k;
      int               roll;
      int               active;
      logic [CMD_W-1:0] code;
      logic [IDX_W-1:0] idx;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-size bitmap, both ends of the index, every command.
      send_cmd(CMD_TEST, 10'd0);
      send_cmd(CMD_SET, 10'd0);
      send_cmd(CMD_SET, 10'd1023);
      send_cmd(CMD_TEST, 10'd1023);
      send_cmd(CMD_FIND_SET, 10'd0);
      send_cmd(CMD_FIND_FREE, 10'd1023);
      send_cmd(CMD_ALLOC_FREE, 10'd0);
      send_cmd(CMD_TAKE_SET, 10'd0);
      send_cmd(CMD_CLEAR, 10'd1023);
      send_cmd(CMD_UNKNOWN, 10'd1023);
      send_cmd(CMD_UNKNOWN, 10'd0);

      // Small count: indexes at and above the bound are out of range.
      write_slot_count(11'd8);
      send_cmd(CMD_SET, 10'd8);
      send_cmd(CMD_CLEAR, 10'd9);
      send_cmd(CMD_TEST, 10'd1023);
      send_cmd(CMD_SET, 10'd7);
      send_cmd(CMD_CLEAR, 10'd1);

      // Count of zero: nothing in range, every search misses.
      write_slot_count(11'd0);
      send_cmd(CMD_FIND_FREE, 10'd5);
      send_cmd(CMD_FIND_SET, 10'd5);
      send_cmd(CMD_ALLOC_FREE, 10'd0);
      send_cmd(CMD_TAKE_SET, 10'd0);
      send_cmd(CMD_SET, 10'd0);

      // Count above capacity behaves as full capacity.
      write_slot_count(11'd2047);
      send_cmd(CMD_SET, 10'd1023);
      send_cmd(CMD_FIND_SET, 10'd0);

      // One slot: allocate until full, take until empty.
      write_slot_count(11'd1);
      send_cmd(CMD_ALLOC_FREE, 10'd0);
      send_cmd(CMD_ALLOC_FREE, 10'd0);
      send_cmd(CMD_TAKE_SET, 10'd0);
      send_cmd(CMD_TAKE_SET, 10'd0);

      // Random phases, each under its own slot count and idle rate.
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph % 6)
            0: write_slot_count(CNT_RESET);
            1: write_slot_count(CNT_W'($urandom_range(1, 48)));
            2: write_slot_count(CNT_W'($urandom_range(1025, 2047)));
            3: write_slot_count(CNT_W'($urandom_range(1, 16)));
            4: write_slot_count(CNT_W'($urandom_range(49, 1024)));
            default: write_slot_count(CNT_W'($urandom_range(0, 8)));
         endcase
         case (ph % 4)
            1:       idle_pct = 75;
            3:       idle_pct = 34;
            default: idle_pct = 0;
         endcase
         active = (cur_count > 11'd1024) ? 1024 : int'(cur_count);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            // Bursts lean toward filling, emptying, or a plain mix.
            bias  = $urandom_range(0, 2);
            burst = $urandom_range(8, 24);
            for (k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
               roll = $urandom_range(0, 99);
               if (roll < 2) code = CMD_UNKNOWN;
               else if (bias == 0 && roll < 55) code = CMD_ALLOC_FREE;
               else if (bias == 0 && roll < 65) code = CMD_SET;
               else if (bias == 1 && roll < 55) code = CMD_TAKE_SET;
               else if (bias == 1 && roll < 65) code = CMD_CLEAR;
               else code = CMD_W'($urandom_range(0, 6));
               if ($urandom_range(0, 99) < 70)
                  idx = IDX_W'($urandom_range(0, (active + 1 > 1023) ? 1023 : active + 1));
               else
                  idx = IDX_W'($urandom_range(0, 1023));
               send_cmd(code, idx);
               sent++;
               if ($urandom_range(0, 99) == 0) wait_for_drain();
            end
         end
      end

      // Let every owed reply arrive, then let the clock run on idle.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d commands over %0d slot-count settings, zero and one slot up to",
               commands_sent, settings_used);
      $display("above capacity; fill and drain bursts, unknown codes, sender idle 0/34/75 pct.");
      if (fail_count == 0 && replies_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
